@@ src/mcgd_pkg.sv @@
`timescale 1ns / 1ps

package mcgd_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_CLICK_WINDOW     = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_MOTION_THRESHOLD = CFG_ADDR_W'(1);

    localparam logic [15:0] CLICK_WINDOW_RESET     = 16'd400;
    localparam logic [14:0] MOTION_THRESHOLD_RESET = 15'd5;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_BUTTON  = 2'd1;
    localparam logic [1:0] MODE_MOTION  = 2'd2;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    localparam logic [3:0] AXIS_HORIZONTAL = 4'd0;
    localparam logic [3:0] AXIS_VERTICAL   = 4'd1;

    localparam logic signed [15:0] BUTTON_PRESSED  = 16'sd1;
    localparam logic signed [15:0] BUTTON_RELEASED = 16'sd0;

    localparam logic [1:0] CLICK_RUN_LAST = 2'd3;

    localparam logic [2:0] MSG_CLICK1 = 3'd0;
    localparam logic [2:0] MSG_CLICK2 = 3'd1;
    localparam logic [2:0] MSG_STOP   = 3'd2;
    localparam logic [2:0] MSG_RESET  = 3'd3;
    localparam logic [2:0] MSG_RIGHT  = 3'd4;
    localparam logic [2:0] MSG_LEFT   = 3'd5;
    localparam logic [2:0] MSG_UP     = 3'd6;
    localparam logic [2:0] MSG_START  = 3'd7;

    localparam logic [1:0] STEP_IDLE  = 2'd0;
    localparam logic [1:0] STEP_RIGHT = 2'd1;
    localparam logic [1:0] STEP_LEFT  = 2'd2;
    localparam logic [1:0] STEP_UP    = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         axis;
        logic signed [15:0] amount;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_stage;

    typedef struct packed {
        logic [15:0] click_window;
        logic [14:0] motion_threshold;
    } t_cfg;

endpackage

@@ src/mcgd_if.sv @@
`timescale 1ns / 1ps

interface mcgd_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [3:0]         axis;
    logic signed [15:0] amount;

    modport source (output valid, output mode, output axis, output amount, input ready);
    modport sink (input valid, input mode, input axis, input amount, output ready);
endinterface

interface mcgd_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] message_code;
    logic [1:0] combo_step_now;

    modport source (output valid, output message_code, output combo_step_now, input ready);
    modport sink (input valid, input message_code, input combo_step_now, output ready);
endinterface

interface mcgd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mcgd_pkg::CFG_ADDR_W-1:0]    addr;
    logic [mcgd_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

@@ src/mcgd_cfg_regs.sv @@
`timescale 1ns / 1ps

module mcgd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mcgd_cfg_if.sink       i_cfg,
    output mcgd_pkg::t_cfg o_cfg
);

    logic [15:0] r_click_window;
    logic [14:0] r_motion_threshold;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_window     <= mcgd_pkg::CLICK_WINDOW_RESET;
            r_motion_threshold <= mcgd_pkg::MOTION_THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                mcgd_pkg::CFG_CLICK_WINDOW: begin
                    r_click_window <= i_cfg.wdata;
                end
                mcgd_pkg::CFG_MOTION_THRESHOLD: begin
                    r_motion_threshold <= i_cfg.wdata[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.click_window     = r_click_window;
    assign o_cfg.motion_threshold = r_motion_threshold;

endmodule

@@ src/mcgd_event_stage.sv @@
`timescale 1ns / 1ps

module mcgd_event_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcgd_event_if.sink       i_evt,
    input  logic             i_take,
    output mcgd_pkg::t_stage o_stage
);

    logic            r_valid;
    mcgd_pkg::t_event r_evt;
    logic            w_ready;

    assign w_ready     = !r_valid || i_take;
    assign i_evt.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_evt.valid) begin
            r_evt.mode   <= i_evt.mode;
            r_evt.axis   <= i_evt.axis;
            r_evt.amount <= i_evt.amount;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.evt   = r_evt;

endmodule

@@ src/mcgd_engine.sv @@
`timescale 1ns / 1ps

module mcgd_engine #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcgd_pkg::t_stage i_stage,
    input  mcgd_pkg::t_cfg   i_cfg,
    output logic             o_take,
    mcgd_result_if.source    o_res
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    logic [TICK_COUNT_WIDTH-1:0] r_ticks;
    logic [1:0]                  r_run;
    logic                        r_held;
    logic [1:0]                  r_step;
    logic                        r_out_valid;
    logic [2:0]                  r_code;
    logic [1:0]                  r_step_now;

    logic [TICK_COUNT_WIDTH-1:0] n_ticks;
    logic [1:0]                  n_run;
    logic                        n_held;
    logic [1:0]                  n_step;

    logic                        w_has;
    logic [2:0]                  w_code;
    logic                        w_in_window;
    logic [1:0]                  w_run_inc;
    logic signed [16:0]          w_amt;
    logic signed [16:0]          w_thr;
    logic signed [16:0]          w_nthr;
    logic                        w_pos;
    logic                        w_neg;
    logic                        w_out_free;
    logic                        w_fire;

    assign w_in_window = CMP_W'(r_ticks) < CMP_W'(i_cfg.click_window);
    assign w_run_inc   = w_in_window ? (r_run + 2'd1) : 2'd1;
    assign w_amt       = 17'(i_stage.evt.amount);
    assign w_thr       = $signed({2'b00, i_cfg.motion_threshold});
    assign w_nthr      = -w_thr;
    assign w_pos       = w_amt > w_thr;
    assign w_neg       = w_amt < w_nthr;

    always_comb begin
        n_ticks = r_ticks;
        n_run   = r_run;
        n_held  = r_held;
        n_step  = r_step;
        w_has   = 1'b0;
        w_code  = mcgd_pkg::MSG_CLICK1;
        case (i_stage.evt.mode)
            mcgd_pkg::MODE_TICK: begin
                if (r_ticks != '1) begin
                    n_ticks = r_ticks + 1'b1;
                end
            end
            mcgd_pkg::MODE_BUTTON: begin
                if (i_stage.evt.amount == mcgd_pkg::BUTTON_PRESSED) begin
                    n_held  = 1'b1;
                    n_ticks = '0;
                    w_has   = 1'b1;
                    n_run   = w_run_inc;
                    if (w_run_inc == 2'd1) begin
                        w_code = mcgd_pkg::MSG_CLICK1;
                    end else if (w_run_inc == 2'd2) begin
                        w_code = mcgd_pkg::MSG_CLICK2;
                    end else begin
                        w_code = mcgd_pkg::MSG_STOP;
                        n_run  = 2'd0;
                    end
                end else if (i_stage.evt.amount == mcgd_pkg::BUTTON_RELEASED) begin
                    n_held = 1'b0;
                    n_step = mcgd_pkg::STEP_IDLE;
                    if (r_step != mcgd_pkg::STEP_IDLE) begin
                        w_has  = 1'b1;
                        w_code = mcgd_pkg::MSG_RESET;
                    end
                end
            end
            mcgd_pkg::MODE_MOTION: begin
                if (r_held) begin
                    if (r_step == mcgd_pkg::STEP_IDLE
                        && i_stage.evt.axis == mcgd_pkg::AXIS_HORIZONTAL && w_pos) begin
                        n_step = mcgd_pkg::STEP_RIGHT;
                        w_has  = 1'b1;
                        w_code = mcgd_pkg::MSG_RIGHT;
                    end else if (r_step == mcgd_pkg::STEP_RIGHT
                        && i_stage.evt.axis == mcgd_pkg::AXIS_HORIZONTAL && w_neg) begin
                        n_step = mcgd_pkg::STEP_LEFT;
                        w_has  = 1'b1;
                        w_code = mcgd_pkg::MSG_LEFT;
                    end else if (r_step == mcgd_pkg::STEP_LEFT
                        && i_stage.evt.axis == mcgd_pkg::AXIS_VERTICAL && w_neg) begin
                        n_step = mcgd_pkg::STEP_UP;
                        w_has  = 1'b1;
                        w_code = mcgd_pkg::MSG_UP;
                    end else if (r_step == mcgd_pkg::STEP_UP
                        && i_stage.evt.axis == mcgd_pkg::AXIS_VERTICAL && w_pos) begin
                        n_step = mcgd_pkg::STEP_IDLE;
                        w_has  = 1'b1;
                        w_code = mcgd_pkg::MSG_START;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_fire     = i_stage.valid && (!w_has || w_out_free);
    assign o_take     = w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks     <= '1;
            r_run       <= 2'd0;
            r_held      <= 1'b0;
            r_step      <= mcgd_pkg::STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ticks <= n_ticks;
                r_run   <= n_run;
                r_held  <= n_held;
                r_step  <= n_step;
            end
            if (w_fire && w_has) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_has) begin
            r_code     <= w_code;
            r_step_now <= n_step;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.message_code   = r_code;
    assign o_res.combo_step_now = r_step_now;

endmodule

@@ src/mouse_click_and_gesture_detector.sv @@
`timescale 1ns / 1ps

// Mouse click and gesture detector. Events enter on i_evt and at most one message per event
// leaves on o_res; the block accepts one event every cycle while no message waits on a stalled
// o_res. Events flow through an input register and then a result register, which holds the
// message on o_res; the tick counter, click run and combo state are updated between them, so
// the only thing that slows intake is a message waiting in the result register while o_res is
// stalled; events that produce no message still pass through in that case only once the
// state ahead of them has been committed. Registers are written on i_cfg (index 0 is the
// click window, index 1 the motion threshold) and should change only while no transaction
// is in flight.
module mouse_click_and_gesture_detector #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcgd_event_if.sink    i_evt,
    mcgd_cfg_if.sink      i_cfg,
    mcgd_result_if.source o_res
);

    mcgd_pkg::t_cfg   w_cfg;
    mcgd_pkg::t_stage w_stage;
    logic             w_take;

    mcgd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    mcgd_event_stage u_event_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    mcgd_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .i_cfg   (w_cfg),
        .o_take  (w_take),
        .o_res   (o_res)
    );

endmodule

@@ src/mcgd_checker.sv @@
`timescale 1ns / 1ps

module mcgd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [2:0] i_res_code,
    input logic [1:0] i_res_step
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_code) && $stable(i_res_step))
        else $error("Result changed while stalled.");

    a_idle_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_code == mcgd_pkg::MSG_START
            || i_res_code == mcgd_pkg::MSG_RESET) |->
            i_res_step == mcgd_pkg::STEP_IDLE)
        else $error("Combo not idle after start or reset.");

    a_right_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_code == mcgd_pkg::MSG_RIGHT |->
            i_res_step == mcgd_pkg::STEP_RIGHT)
        else $error("Right message with wrong combo step.");

    a_up_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_code == mcgd_pkg::MSG_UP |->
            i_res_step == mcgd_pkg::STEP_UP)
        else $error("Up message with wrong combo step.");

endmodule

bind mouse_click_and_gesture_detector mcgd_checker u_mcgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_code  (o_res.message_code),
    .i_res_step  (o_res.combo_step_now)
);
